// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/spm_pkg.sv =====
// Package: widths, command codes and controller/datapath interface types.
`timescale 1ns / 1ps
package spm_pkg;

	localparam int DEF_MAX_TERMS = 8;

	localparam int CMD_W   = 2;
	localparam int COEFF_W = 16;
	localparam int EXP_W   = 8;
	localparam int PROD_W  = 32;
	localparam int PEXP_W  = 9;

	localparam logic [CMD_W-1:0] CMD_LOAD_FIRST  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_SECOND = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPUTE     = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR       = 2'd3;

	// Controller -> datapath
	typedef struct packed {
		logic load_first;
		logic load_second;
		logic clear;
		logic start;      // reset pair, table and emit counters
		logic mul;        // form product of the current pair
		logic scan;       // search the product table
		logic emit_sel;   // table read address follows the emit counter
		logic emit_load;  // move a table entry into the output register
		logic empty_load; // load the empty-product result
	} ctrl_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic store_empty;
		logic merge_done;
		logic last_pair;
		logic emit_last;
		logic out_free;
	} dp_status_t;

endpackage

// ===== hw/rtl/sparse_polynomial_multiplier_core.sv =====
// Top level: sparse polynomial multiplier core.
//
//  channel   signals                                         direction
//  in        in_valid/in_stall, command, term_coeff,         into block
//            term_exponent
//  out       out_valid/out_stall, product_coeff,              out of block
//            product_exponent, last_term, empty_product,
//            terms_dropped
//
// Load and clear transfers do not stall input; in_stall is high from a compute
// transfer until its last result sits in the output register.
// Compute: per term pair, one multiply step and then a scan of the table entries so far
// through the single read port of the product table.
// Emit: each result is a table read, then an output load; the load waits while out_stall is high.
// No clearing pass after reset; the product table is rebuilt on every compute.
`timescale 1ns / 1ps
module sparse_polynomial_multiplier_core #(
	parameter int MAX_TERMS = spm_pkg::DEF_MAX_TERMS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic        [spm_pkg::CMD_W-1:0]   command,
	input  logic signed [spm_pkg::COEFF_W-1:0] term_coeff,
	input  logic        [spm_pkg::EXP_W-1:0]   term_exponent,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [spm_pkg::PROD_W-1:0]  product_coeff,
	output logic        [spm_pkg::PEXP_W-1:0]  product_exponent,
	output logic                               last_term,
	output logic                               empty_product,
	output logic                               terms_dropped
);
	import spm_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	spm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.command  (command),
		.status   (status),
		.cmd      (cmd)
	);

	spm_datapath #(
		.MAX_TERMS (MAX_TERMS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.term_coeff       (term_coeff),
		.term_exponent    (term_exponent),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.product_coeff    (product_coeff),
		.product_exponent (product_exponent),
		.last_term        (last_term),
		.empty_product    (empty_product),
		.terms_dropped    (terms_dropped)
	);

endmodule

// ===== hw/rtl/spm_datapath.sv =====
// Datapath: term stores, multiplier, product table with scan, output register.
`timescale 1ns / 1ps
module spm_datapath #(
	parameter int MAX_TERMS = spm_pkg::DEF_MAX_TERMS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  spm_pkg::ctrl_cmd_t                 cmd,
	output spm_pkg::dp_status_t                status,
	input  logic signed [spm_pkg::COEFF_W-1:0] term_coeff,
	input  logic        [spm_pkg::EXP_W-1:0]   term_exponent,
	input  logic                               out_stall,
	output logic                               out_valid,
	output logic signed [spm_pkg::PROD_W-1:0]  product_coeff,
	output logic        [spm_pkg::PEXP_W-1:0]  product_exponent,
	output logic                               last_term,
	output logic                               empty_product,
	output logic                               terms_dropped
);
	import spm_pkg::*;

	localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CNT_W     = $clog2(MAX_TERMS + 1);
	localparam int CMP_W     = CNT_W + 1;
	localparam int TAB_DEPTH = MAX_TERMS * MAX_TERMS;
	localparam int TAB_AW    = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;
	localparam int USED_W    = $clog2(TAB_DEPTH + 1);

	// term stores
	logic signed [COEFF_W-1:0] first_coeff_q  [MAX_TERMS];
	logic        [EXP_W-1:0]   first_exp_q    [MAX_TERMS];
	logic signed [COEFF_W-1:0] second_coeff_q [MAX_TERMS];
	logic        [EXP_W-1:0]   second_exp_q   [MAX_TERMS];
	logic [CNT_W-1:0] first_cnt_q, second_cnt_q;
	logic             dropped_q;

	// product table
	logic signed [PROD_W-1:0] tab_coeff [TAB_DEPTH];
	logic        [PEXP_W-1:0] tab_exp   [TAB_DEPTH];

	logic [IDX_W-1:0]  i_q, j_q;
	logic [USED_W-1:0] used_q, k_q, e_q;
	logic signed [PROD_W-1:0] prod_q;
	logic        [PEXP_W-1:0] pexp_q;

	logic                     rv_s1;
	logic [USED_W-1:0]        rk_s1;
	logic signed [PROD_W-1:0] rd_coeff_s1;
	logic        [PEXP_W-1:0] rd_exp_s1;
	logic [TAB_AW-1:0]        rd_addr;

	logic out_valid_q;
	logic i_last, j_last, hit, miss_end, k_live;

	assign i_last   = (CMP_W'(i_q) + CMP_W'(1)) == CMP_W'(first_cnt_q);
	assign j_last   = (CMP_W'(j_q) + CMP_W'(1)) == CMP_W'(second_cnt_q);
	assign k_live   = k_q < used_q;
	assign hit      = rv_s1 && (rd_exp_s1 == pexp_q);
	assign miss_end = (used_q == '0) || (rv_s1 && !hit && ((rk_s1 + USED_W'(1)) == used_q));
	assign rd_addr  = cmd.emit_sel ? e_q[TAB_AW-1:0] : k_q[TAB_AW-1:0];

	assign status.store_empty = (first_cnt_q == '0) || (second_cnt_q == '0);
	assign status.merge_done  = hit || miss_end;
	assign status.last_pair   = i_last && j_last;
	assign status.emit_last   = (e_q + USED_W'(1)) == used_q;
	assign status.out_free    = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;

	// store contents
	always_ff @(posedge clk) begin
		if (cmd.load_first && (first_cnt_q < CNT_W'(MAX_TERMS))) begin
			first_coeff_q[first_cnt_q[IDX_W-1:0]] <= term_coeff;
			first_exp_q[first_cnt_q[IDX_W-1:0]]   <= term_exponent;
		end
		if (cmd.load_second && (second_cnt_q < CNT_W'(MAX_TERMS))) begin
			second_coeff_q[second_cnt_q[IDX_W-1:0]] <= term_coeff;
			second_exp_q[second_cnt_q[IDX_W-1:0]]   <= term_exponent;
		end
	end

	// multiplier stage, table read and table write
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= first_coeff_q[i_q] * second_coeff_q[j_q];
			pexp_q <= PEXP_W'(first_exp_q[i_q]) + PEXP_W'(second_exp_q[j_q]);
		end
		rk_s1       <= k_q;
		rd_coeff_s1 <= tab_coeff[rd_addr];
		rd_exp_s1   <= tab_exp[rd_addr];
		if (cmd.scan && hit) begin
			tab_coeff[rk_s1[TAB_AW-1:0]] <= rd_coeff_s1 + prod_q;
		end else if (cmd.scan && miss_end) begin
			tab_coeff[used_q[TAB_AW-1:0]] <= prod_q;
			tab_exp[used_q[TAB_AW-1:0]]   <= pexp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_cnt_q  <= '0;
			second_cnt_q <= '0;
			dropped_q    <= 1'b0;
			i_q          <= '0;
			j_q          <= '0;
			used_q       <= '0;
			k_q          <= '0;
			e_q          <= '0;
			rv_s1        <= 1'b0;
		end else begin
			if (cmd.clear) begin
				first_cnt_q  <= '0;
				second_cnt_q <= '0;
				dropped_q    <= 1'b0;
			end
			if (cmd.load_first) begin
				if (first_cnt_q < CNT_W'(MAX_TERMS)) begin
					first_cnt_q <= first_cnt_q + CNT_W'(1);
				end else begin
					dropped_q <= 1'b1;
				end
			end
			if (cmd.load_second) begin
				if (second_cnt_q < CNT_W'(MAX_TERMS)) begin
					second_cnt_q <= second_cnt_q + CNT_W'(1);
				end else begin
					dropped_q <= 1'b1;
				end
			end
			rv_s1 <= cmd.scan && k_live;
			if (cmd.start) begin
				i_q    <= '0;
				j_q    <= '0;
				used_q <= '0;
				e_q    <= '0;
			end
			if (cmd.mul) begin
				k_q <= '0;
			end else if (cmd.scan && k_live) begin
				k_q <= k_q + USED_W'(1);
			end
			if (cmd.scan && (hit || miss_end)) begin
				if (miss_end) begin
					used_q <= used_q + USED_W'(1);
				end
				if (j_last) begin
					j_q <= '0;
					i_q <= i_q + IDX_W'(1);
				end else begin
					j_q <= j_q + IDX_W'(1);
				end
			end
			if (cmd.emit_load) begin
				e_q <= e_q + USED_W'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_load || cmd.empty_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			product_coeff    <= rd_coeff_s1;
			product_exponent <= rd_exp_s1;
			last_term        <= status.emit_last;
			empty_product    <= 1'b0;
			terms_dropped    <= dropped_q;
		end else if (cmd.empty_load) begin
			product_coeff    <= '0;
			product_exponent <= '0;
			last_term        <= 1'b1;
			empty_product    <= 1'b1;
			terms_dropped    <= dropped_q;
		end
	end

endmodule

// ===== hw/rtl/spm_ctrl.sv =====
// Controller: sequences load, multiply/merge and emit phases.
`timescale 1ns / 1ps
module spm_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [spm_pkg::CMD_W-1:0] command,
	input  spm_pkg::dp_status_t       status,
	output spm_pkg::ctrl_cmd_t        cmd
);
	import spm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SCAN,
		ST_ERD,
		ST_EOUT,
		ST_EMPTY
	} state_t;

	state_t state_q;
	logic   take;

	assign in_stall = (state_q != ST_IDLE);
	assign take     = (state_q == ST_IDLE) && in_valid;

	always_comb begin
		cmd             = '0;
		cmd.load_first  = take && (command == CMD_LOAD_FIRST);
		cmd.load_second = take && (command == CMD_LOAD_SECOND);
		cmd.clear       = take && (command == CMD_CLEAR);
		cmd.start       = take && (command == CMD_COMPUTE);
		cmd.mul         = (state_q == ST_MUL);
		cmd.scan        = (state_q == ST_SCAN);
		cmd.emit_sel    = (state_q == ST_ERD) || (state_q == ST_EOUT);
		cmd.emit_load   = (state_q == ST_EOUT) && status.out_free;
		cmd.empty_load  = (state_q == ST_EMPTY) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take && (command == CMD_COMPUTE)) begin
						state_q <= status.store_empty ? ST_EMPTY : ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (status.merge_done) begin
						state_q <= status.last_pair ? ST_ERD : ST_MUL;
					end
				end
				ST_ERD: begin
					state_q <= ST_EOUT;
				end
				ST_EOUT: begin
					if (status.out_free) begin
						state_q <= status.emit_last ? ST_IDLE : ST_ERD;
					end
				end
				ST_EMPTY: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/spm_checker.sv =====
// Port-level checker for the sparse polynomial multiplier core, with bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module spm_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic        [spm_pkg::CMD_W-1:0]   command,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [spm_pkg::PROD_W-1:0]  product_coeff,
	input logic        [spm_pkg::PEXP_W-1:0]  product_exponent,
	input logic                               last_term,
	input logic                               empty_product
);
	import spm_pkg::*;

	// a stalled result holds
	`SPM_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(product_coeff) && $stable(product_exponent) && $stable(last_term), "stalled result changed")

	// empty result is a single zero term
	`SPM_ASSERT_NOW(a_empty_form, clk, arst_n, out_valid && empty_product, last_term && (product_coeff == '0) && (product_exponent == '0), "malformed empty result")

	// compute transfer blocks further input
	`SPM_ASSERT_NXT(a_compute_busy, clk, arst_n, in_valid && !in_stall && (command == CMD_COMPUTE), in_stall, "compute did not stall input")

	// load and clear do not stall input
	`SPM_ASSERT_NXT(a_load_quick, clk, arst_n, in_valid && !in_stall && (command != CMD_COMPUTE), !in_stall, "load or clear stalled input")

endmodule

bind sparse_polynomial_multiplier_core spm_checker u_spm_checker (.*);

// ===== dv/tb_sparse_polynomial_multiplier_core.sv =====
// Testbench for the sparse polynomial multiplier core: random and directed term streams.
`timescale 1ns / 1ps
module tb_sparse_polynomial_multiplier_core;
	import spm_pkg::*;

	localparam int STORE_CAP = (DEF_MAX_TERMS > 8) ? 8 : DEF_MAX_TERMS;
	localparam int ITEM_TARGET = 135;

	typedef struct {
		logic signed [PROD_W-1:0] coeff;
		logic        [PEXP_W-1:0] exponent;
		logic                     last;
		logic                     empty;
		logic                     dropped;
	} product_term_t;

	// Mirror of the term stores; builds the product table on each compute transfer.
	class poly_scoreboard;
		logic signed [COEFF_W-1:0] first_coeff[8];
		logic        [EXP_W-1:0]   first_exp[8];
		logic signed [COEFF_W-1:0] second_coeff[8];
		logic        [EXP_W-1:0]   second_exp[8];
		int first_n;
		int second_n;
		bit dropped;
		product_term_t awaited[$];
		int fails;
		int checked;
		int computes;
		int empty_runs;
		int dropped_runs;

		function void flag(string what);
			fails++;
			if (fails <= 10)
				$display("%t mismatch: %s", $realtime, what);
		endfunction

		function void note_transfer(logic [CMD_W-1:0] cmd, logic signed [COEFF_W-1:0] c,
				logic [EXP_W-1:0] e);
			logic signed [PROD_W-1:0] acc[64];
			logic        [PEXP_W-1:0] exps[64];
			logic signed [PROD_W-1:0] p;
			logic        [PEXP_W-1:0] x;
			int used;
			bit hit;
			product_term_t t;
			case (cmd)
				CMD_LOAD_FIRST: begin
					if (first_n >= STORE_CAP) begin
						dropped = 1'b1;
					end else begin
						first_coeff[first_n] = c;
						first_exp[first_n] = e;
						first_n++;
					end
				end
				CMD_LOAD_SECOND: begin
					if (second_n >= STORE_CAP) begin
						dropped = 1'b1;
					end else begin
						second_coeff[second_n] = c;
						second_exp[second_n] = e;
						second_n++;
					end
				end
				CMD_CLEAR: begin
					first_n = 0;
					second_n = 0;
					dropped = 1'b0;
				end
				default: begin
					computes++;
					if (dropped)
						dropped_runs++;
					used = 0;
					for (int i = 0; i < first_n; i++) begin
						for (int j = 0; j < second_n; j++) begin
							p = first_coeff[i] * second_coeff[j];
							x = PEXP_W'(first_exp[i]) + PEXP_W'(second_exp[j]);
							hit = 1'b0;
							for (int k = 0; k < used; k++) begin
								if (!hit && exps[k] == x) begin
									acc[k] = acc[k] + p;
									hit = 1'b1;
								end
							end
							if (!hit) begin
								acc[used] = p;
								exps[used] = x;
								used++;
							end
						end
					end
					if (used == 0) begin
						empty_runs++;
						t.coeff = '0;
						t.exponent = '0;
						t.last = 1'b1;
						t.empty = 1'b1;
						t.dropped = dropped;
						awaited.push_back(t);
					end
					for (int k = 0; k < used; k++) begin
						t.coeff = acc[k];
						t.exponent = exps[k];
						t.last = (k == used - 1);
						t.empty = 1'b0;
						t.dropped = dropped;
						awaited.push_back(t);
					end
				end
			endcase
		endfunction

		function void check_result(product_term_t got);
			product_term_t want;
			checked++;
			if (awaited.size() == 0) begin
				flag($sformatf("unexpected result coeff=%0d exp=%0d", got.coeff, got.exponent));
				return;
			end
			want = awaited.pop_front();
			if (got.coeff !== want.coeff || got.exponent !== want.exponent
					|| got.last !== want.last || got.empty !== want.empty
					|| got.dropped !== want.dropped)
				flag($sformatf({"expected coeff=%0d exp=%0d last=%b empty=%b dropped=%b, ",
					"got coeff=%0d exp=%0d last=%b empty=%b dropped=%b"},
					want.coeff, want.exponent, want.last, want.empty, want.dropped,
					got.coeff, got.exponent, got.last, got.empty, got.dropped));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CMD_W-1:0] command = CMD_CLEAR;
	logic signed [COEFF_W-1:0] term_coeff = '0;
	logic [EXP_W-1:0] term_exponent = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [PROD_W-1:0] product_coeff;
	logic [PEXP_W-1:0] product_exponent;
	logic last_term;
	logic empty_product;
	logic terms_dropped;

	poly_scoreboard board = new;
	bit quiet_stretch = 1'b0;
	int sent = 0;

	sparse_polynomial_multiplier_core u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.command         (command),
		.term_coeff      (term_coeff),
		.term_exponent   (term_exponent),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.product_coeff   (product_coeff),
		.product_exponent(product_exponent),
		.last_term       (last_term),
		.empty_product   (empty_product),
		.terms_dropped   (terms_dropped)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= !quiet_stretch && ($urandom_range(99) < 18);
	end

	always @(posedge clk) begin
		product_term_t got;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			got.coeff = product_coeff;
			got.exponent = product_exponent;
			got.last = last_term;
			got.empty = empty_product;
			got.dropped = terms_dropped;
			board.check_result(got);
		end
	end

	task automatic send(logic [CMD_W-1:0] cmd, logic signed [COEFF_W-1:0] c,
			logic [EXP_W-1:0] e);
		while (!quiet_stretch && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		term_coeff <= c;
		term_exponent <= e;
		do @(posedge clk); while (in_stall);
		board.note_transfer(cmd, c, e);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.awaited.size() != 0) @(posedge clk);
	endtask

	function automatic logic signed [COEFF_W-1:0] pick_coeff();
		case ($urandom_range(19))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return 16'sd0;
			3: return -16'sd1;
			default: return COEFF_W'($urandom);
		endcase
	endfunction

	// Mostly small exponents so that products collide and merge.
	function automatic logic [EXP_W-1:0] pick_exp();
		if ($urandom_range(99) < 70)
			return EXP_W'($urandom_range(5));
		return EXP_W'($urandom);
	endfunction

	function automatic int pick_size();
		if ($urandom_range(99) < 15)
			return $urandom_range(10, 5);
		return $urandom_range(4);
	endfunction

	initial begin
		int n1;
		int n2;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Both stores empty, then only the first loaded, then both loaded.
		send(CMD_COMPUTE, 16'sd0, 8'd0);
		send(CMD_LOAD_FIRST, 16'sd32767, 8'd255);
		send(CMD_COMPUTE, 16'sd0, 8'd0);
		send(CMD_LOAD_SECOND, -16'sd32768, 8'd255);
		send(CMD_COMPUTE, 16'sd0, 8'd0);
		// Fill the first store, one more term is dropped.
		for (int i = 0; i < STORE_CAP; i++)
			send(CMD_LOAD_FIRST, pick_coeff(), EXP_W'(i));
		send(CMD_COMPUTE, 16'sd0, 8'd0);
		send(CMD_CLEAR, 16'sd0, 8'd0);
		// Two 2^30 products on one exponent wrap the sum.
		send(CMD_LOAD_FIRST, -16'sd32768, 8'd0);
		send(CMD_LOAD_FIRST, -16'sd32768, 8'd1);
		send(CMD_LOAD_SECOND, -16'sd32768, 8'd1);
		send(CMD_LOAD_SECOND, -16'sd32768, 8'd0);
		send(CMD_COMPUTE, 16'sd0, 8'd0);
		send(CMD_CLEAR, 16'sd0, 8'd0);
		// Exponent 1 cancels to zero and must still come out; computed twice.
		send(CMD_LOAD_FIRST, 16'sd1, 8'd0);
		send(CMD_LOAD_FIRST, 16'sd1, 8'd1);
		send(CMD_LOAD_SECOND, 16'sd1, 8'd1);
		send(CMD_LOAD_SECOND, -16'sd1, 8'd0);
		send(CMD_COMPUTE, 16'sd0, 8'd0);
		send(CMD_COMPUTE, 16'sd0, 8'd0);
		drain();

		while (sent < ITEM_TARGET) begin
			quiet_stretch = (sent >= 80 && sent < 115);
			if ($urandom_range(99) < 8) begin
				send(CMD_W'($urandom), COEFF_W'($urandom), EXP_W'($urandom));
			end else begin
				if ($urandom_range(99) < 60)
					send(CMD_CLEAR, COEFF_W'($urandom), EXP_W'($urandom));
				n1 = pick_size();
				n2 = pick_size();
				while (n1 > 0 || n2 > 0) begin
					if (n2 == 0 || (n1 > 0 && $urandom_range(1))) begin
						send(CMD_LOAD_FIRST, pick_coeff(), pick_exp());
						n1--;
					end else begin
						send(CMD_LOAD_SECOND, pick_coeff(), pick_exp());
						n2--;
					end
				end
				send(CMD_COMPUTE, COEFF_W'($urandom), EXP_W'($urandom));
				if ($urandom_range(99) < 20)
					send(CMD_COMPUTE, COEFF_W'($urandom), EXP_W'($urandom));
			end
			if ($urandom_range(99) < 10)
				drain();
		end

		drain();
		repeat (50) @(posedge clk);
		$display("Sent %0d transfers: %0d compute runs, %0d empty, %0d with dropped terms.",
			sent, board.computes, board.empty_runs, board.dropped_runs);
		$display("Checked %0d product terms, %0d failures.", board.checked, board.fails);
		if (board.fails == 0 && board.awaited.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("Timeout with %0d results still awaited.", board.awaited.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/spm_pkg.sv
hw/rtl/spm_datapath.sv
hw/rtl/spm_ctrl.sv
hw/rtl/sparse_polynomial_multiplier_core.sv
hw/rtl/spm_checker.sv
dv/tb_sparse_polynomial_multiplier_core.sv
